// File: sv/lsmt_pkg.sv
// Package with the shared types and constants of the line segment map table.
package lsmt_pkg;

   localparam int SEGMENTS = 256;
   localparam int IDX_W    = $clog2(SEGMENTS);
   localparam int CNT_W    = $clog2(SEGMENTS + 1);
   localparam int FILE_W   = 8;
   localparam int LINE_W   = 31;
   localparam int MAP_W    = 32;
   localparam int ENTRY_W  = 8;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_FIND   = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic read_fin;
   } cmd_type;

   typedef struct packed {
      logic go_scan;
      logic go_read;
      logic scan_end;
   } stat_type;

   typedef struct packed {
      logic [FILE_W-1:0] file;
      logic [LINE_W-1:0] start;
      logic [MAP_W-1:0]  pre;
      logic [LINE_W-1:0] orig;
   } seg_type;

endpackage

// File: sv/lsmt_ctrl.sv
// Controller state machine that sequences accept, table scan, read and response.
module lsmt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output lsmt_pkg::cmd_type  cmd,
   input  lsmt_pkg::stat_type stat
);
   import lsmt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (stat.go_scan) begin
                  state_in = S_SCAN;
               end else if (stat.go_read) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      cmd.accept   = 1'b0;
      cmd.scan     = 1'b0;
      cmd.read_fin = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
         end
         S_READ: begin
            cmd.read_fin = 1'b1;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/lsmt_dp.sv
// Datapath with the segment memory, scan pointer, segment count and result register.
module lsmt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  lsmt_pkg::cmd_type             cmd,
   output lsmt_pkg::stat_type            stat,
   input  lsmt_pkg::op_type              req_op,
   input  logic [lsmt_pkg::FILE_W-1:0]   req_file,
   input  logic [lsmt_pkg::LINE_W-1:0]   req_orig,
   input  logic [lsmt_pkg::LINE_W-1:0]   req_line,
   input  logic [lsmt_pkg::ENTRY_W-1:0]  req_index,
   output lsmt_pkg::status_type          res_status,
   output logic [lsmt_pkg::FILE_W-1:0]   res_file,
   output logic [lsmt_pkg::MAP_W-1:0]    res_pre,
   output logic [lsmt_pkg::MAP_W-1:0]    res_orig,
   output logic [lsmt_pkg::LINE_W-1:0]   res_start
);
   import lsmt_pkg::*;

   seg_type seg_mem [SEGMENTS];
   seg_type rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   seg_type          wr_data;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [LINE_W-1:0] nstart_ff, nstart_in;
   op_type            op_ff, op_in;
   logic [FILE_W-1:0] fid_ff, fid_in;
   logic [LINE_W-1:0] orig_ff, orig_in;
   logic [LINE_W-1:0] line_ff, line_in;

   status_type        status_ff, status_in;
   logic [FILE_W-1:0] rfile_ff, rfile_in;
   logic [MAP_W-1:0]  rpre_ff, rpre_in;
   logic [MAP_W-1:0]  rorig_ff, rorig_in;
   logic [LINE_W-1:0] rstart_ff, rstart_in;

   logic [CNT_W-1:0]  count_m1;
   logic [IDX_W-1:0]  last_idx;
   logic              count_zero;
   logic              full;
   logic              idx_ok;
   logic              is_open;
   logic              match_file;
   logic              match_line;
   logic              hit;
   logic [LINE_W-1:0] end_line;
   logic [LINE_W-1:0] span;
   logic [MAP_W-1:0]  base;
   logic [MAP_W-1:0]  off;

   assign count_m1   = count_ff - CNT_W'(1);
   assign last_idx   = count_m1[IDX_W-1:0];
   assign count_zero = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(SEGMENTS));
   assign idx_ok     = (CNT_W'(req_index) < count_ff);

   assign stat.go_scan = ((req_op == OP_APPEND) && !full && !count_zero) ||
                         ((req_op == OP_FIND) && !count_zero);
   assign stat.go_read = (req_op == OP_READ) && idx_ok;

   // Only the newest segment is open; every older one ends where the next one starts.
   assign is_open    = (cur_ff == last_idx);
   assign match_file = (rd_ff.file == fid_ff);
   assign match_line = (line_ff >= rd_ff.start) && (is_open || (line_ff < nstart_ff));
   assign hit        = (op_ff == OP_APPEND) ? match_file : match_line;
   assign end_line   = is_open ? line_ff : nstart_ff;
   assign span       = (end_line >= rd_ff.start) ? (end_line - rd_ff.start)
                                                 : (rd_ff.start - end_line);
   assign base       = rd_ff.pre + MAP_W'(span) - MAP_W'(1);
   assign off        = MAP_W'(line_ff - rd_ff.start);

   assign stat.scan_end = hit || (cur_ff == '0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seg_mem[wr_addr] <= wr_data;
      end
      rd_ff <= seg_mem[rd_addr];
   end

   always_comb begin
      count_in  = count_ff;
      cur_in    = cur_ff;
      nstart_in = nstart_ff;
      op_in     = op_ff;
      fid_in    = fid_ff;
      orig_in   = orig_ff;
      line_in   = line_ff;
      status_in = status_ff;
      rfile_in  = rfile_ff;
      rpre_in   = rpre_ff;
      rorig_in  = rorig_ff;
      rstart_in = rstart_ff;
      rd_addr   = cur_ff - IDX_W'(1);
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      wr_data   = '{file: fid_ff, start: line_ff, pre: '0, orig: orig_ff};
      if (cmd.accept) begin
         op_in     = req_op;
         fid_in    = req_file;
         orig_in   = req_orig;
         line_in   = req_line;
         cur_in    = last_idx;
         nstart_in = req_line;
         rd_addr   = (req_op == OP_READ) ? req_index[IDX_W-1:0] : last_idx;
         case (req_op)
            OP_APPEND: begin
               if (full) begin
                  status_in = ST_FULL;
                  rfile_in  = '0;
                  rpre_in   = '0;
                  rorig_in  = '0;
                  rstart_in = '0;
               end else if (count_zero) begin
                  wr_en     = 1'b1;
                  wr_data   = '{file: req_file, start: req_line, pre: '0, orig: req_orig};
                  count_in  = count_ff + CNT_W'(1);
                  status_in = ST_OK;
                  rfile_in  = req_file;
                  rpre_in   = '0;
                  rorig_in  = MAP_W'(req_orig);
                  rstart_in = req_line;
               end
            end
            OP_FIND: begin
               if (count_zero) begin
                  status_in = ST_MISS;
                  rfile_in  = '0;
                  rpre_in   = '1;
                  rorig_in  = '1;
                  rstart_in = '0;
               end
            end
            OP_READ: begin
               if (!idx_ok) begin
                  status_in = ST_MISS;
                  rfile_in  = '0;
                  rpre_in   = '1;
                  rorig_in  = '1;
                  rstart_in = '1;
               end
            end
            OP_CLEAR: begin
               count_in  = '0;
               status_in = ST_OK;
               rfile_in  = '0;
               rpre_in   = '0;
               rorig_in  = '0;
               rstart_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end else if (cmd.scan) begin
         if (stat.scan_end) begin
            case (op_ff)
               OP_APPEND: begin
                  wr_en     = 1'b1;
                  wr_data   = '{file: fid_ff, start: line_ff,
                                pre: hit ? base : '0, orig: orig_ff};
                  count_in  = count_ff + CNT_W'(1);
                  status_in = ST_OK;
                  rfile_in  = fid_ff;
                  rpre_in   = hit ? base : '0;
                  rorig_in  = MAP_W'(orig_ff);
                  rstart_in = line_ff;
               end
               OP_FIND: begin
                  if (hit) begin
                     status_in = ST_OK;
                     rfile_in  = rd_ff.file;
                     rpre_in   = rd_ff.pre + off;
                     rorig_in  = MAP_W'(rd_ff.orig) + off;
                     rstart_in = rd_ff.start;
                  end else begin
                     status_in = ST_MISS;
                     rfile_in  = '0;
                     rpre_in   = '1;
                     rorig_in  = '1;
                     rstart_in = '0;
                  end
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
         end else begin
            cur_in    = cur_ff - IDX_W'(1);
            nstart_in = rd_ff.start;
         end
      end else if (cmd.read_fin) begin
         status_in = ST_OK;
         rfile_in  = rd_ff.file;
         rpre_in   = rd_ff.pre;
         rorig_in  = MAP_W'(rd_ff.orig);
         rstart_in = rd_ff.start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      nstart_ff <= nstart_in;
      op_ff     <= op_in;
      fid_ff    <= fid_in;
      orig_ff   <= orig_in;
      line_ff   <= line_in;
      status_ff <= status_in;
      rfile_ff  <= rfile_in;
      rpre_ff   <= rpre_in;
      rorig_ff  <= rorig_in;
      rstart_ff <= rstart_in;
   end

   assign res_status = status_ff;
   assign res_file   = rfile_ff;
   assign res_pre    = rpre_ff;
   assign res_orig   = rorig_ff;
   assign res_start  = rstart_ff;

endmodule

// File: sv/line_segment_map_table_core.sv
// Top level of the line segment map table with its request and response stream ports.
//
// The block keeps up to 256 line segments in a memory with one write and one read port and
// handles one request at a time. Append and find walk the stored segments from newest to oldest,
// one segment per clock. An append to an empty or full table, a find on an empty table, a read
// with an index out of range and a clear go straight from accept to the response; a valid read
// passes through the read state first.
// Each request produces exactly one response transfer, and the next request is taken
// once that response transfer has completed. Reset empties the table at once.
module line_segment_map_table_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // file_id[7:0], orig_line[38:8], target_line[69:39], entry_index[77:70], zero fill.
   input  logic [79:0]  req_tdata,
   // operation[1:0].
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_file_id[7:0], pre_line[39:8], mapped_orig_line[71:40], start_line[102:72], zero fill.
   output logic [103:0] rsp_tdata,
   // status[1:0].
   output logic [1:0]   rsp_tuser
);
   import lsmt_pkg::*;

   cmd_type           cmd;
   stat_type          stat;
   status_type        res_status;
   logic [FILE_W-1:0] res_file;
   logic [MAP_W-1:0]  res_pre;
   logic [MAP_W-1:0]  res_orig;
   logic [LINE_W-1:0] res_start;
   op_type            req_op;

   assign req_op = op_type'(req_tuser);

   lsmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   lsmt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_op),
      .req_file   (req_tdata[7:0]),
      .req_orig   (req_tdata[38:8]),
      .req_line   (req_tdata[69:39]),
      .req_index  (req_tdata[77:70]),
      .res_status (res_status),
      .res_file   (res_file),
      .res_pre    (res_pre),
      .res_orig   (res_orig),
      .res_start  (res_start)
   );

   assign rsp_tdata = {1'b0, res_start, res_orig, res_pre, res_file};
   assign rsp_tuser = res_status;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for line_segment_map_table_core with a segment table predictor.
`timescale 1ns / 100ps

module tb_top;
   import lsmt_pkg::*;

   localparam int ITEMS       = 1950;
   localparam int QUIET_ITEMS = 150;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 300;
   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

   typedef struct {
      status_type        status;
      logic [FILE_W-1:0] file;
      logic [MAP_W-1:0]  pre;
      logic [MAP_W-1:0]  orig;
      logic [LINE_W-1:0] start;
   } map_result_type;

   class segment_map_scoreboard;
      logic [FILE_W-1:0] seg_file  [SEGMENTS];
      logic [LINE_W-1:0] seg_start [SEGMENTS];
      logic [LINE_W-1:0] seg_end   [SEGMENTS];
      bit                seg_open  [SEGMENTS];
      logic [MAP_W-1:0]  seg_pre   [SEGMENTS];
      logic [LINE_W-1:0] seg_orig  [SEGMENTS];
      int                seg_count;
      map_result_type    mapping_q[$];
      int                errors;
      int                checked;
      int                full_appends;
      int                missed_finds;
      int                bad_indexes;
      int                op_count [4];

      function int pending();
         return mapping_q.size();
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      function void note_request(op_type op, logic [FILE_W-1:0] fid,
                                 logic [LINE_W-1:0] orig, logic [LINE_W-1:0] line,
                                 logic [ENTRY_W-1:0] idx);
         map_result_type    r;
         logic [LINE_W-1:0] hi;
         logic [LINE_W-1:0] lo;
         logic [MAP_W-1:0]  base;
         logic [MAP_W-1:0]  off;
         bit                hit;
         int                k;
         r.status = ST_OK;
         r.file   = '0;
         r.pre    = '0;
         r.orig   = '0;
         r.start  = '0;
         base     = '0;
         hit      = 1'b0;
         op_count[op]++;
         case (op)
            OP_APPEND: begin
               if (seg_count >= SEGMENTS) begin
                  r.status = ST_FULL;
                  full_appends++;
               end else begin
                  for (k = seg_count - 1; k >= 0 && !hit; k--) begin
                     if (seg_file[k] == fid) begin
                        hit  = 1'b1;
                        hi   = seg_open[k] ? line : seg_end[k];
                        lo   = seg_start[k];
                        off  = (hi >= lo) ? {1'b0, hi - lo} : {1'b0, lo - hi};
                        base = seg_pre[k] + off - 32'd1;
                     end
                  end
                  if (seg_count > 0 && seg_open[seg_count - 1]) begin
                     seg_end[seg_count - 1]  = line;
                     seg_open[seg_count - 1] = 1'b0;
                  end
                  seg_file[seg_count]  = fid;
                  seg_start[seg_count] = line;
                  seg_end[seg_count]   = '0;
                  seg_open[seg_count]  = 1'b1;
                  seg_pre[seg_count]   = base;
                  seg_orig[seg_count]  = orig;
                  seg_count++;
                  r.file  = fid;
                  r.pre   = base;
                  r.orig  = {1'b0, orig};
                  r.start = line;
               end
            end
            OP_FIND: begin
               r.status = ST_MISS;
               r.pre    = '1;
               r.orig   = '1;
               for (k = seg_count - 1; k >= 0 && !hit; k--) begin
                  if (line >= seg_start[k] && (seg_open[k] || line < seg_end[k])) begin
                     hit      = 1'b1;
                     off      = {1'b0, line - seg_start[k]};
                     r.status = ST_OK;
                     r.file   = seg_file[k];
                     r.pre    = seg_pre[k] + off;
                     r.orig   = {1'b0, seg_orig[k]} + off;
                     r.start  = seg_start[k];
                  end
               end
               if (!hit)
                  missed_finds++;
            end
            OP_READ: begin
               if (idx < seg_count) begin
                  r.file  = seg_file[idx];
                  r.pre   = seg_pre[idx];
                  r.orig  = {1'b0, seg_orig[idx]};
                  r.start = seg_start[idx];
               end else begin
                  r.status = ST_MISS;
                  r.pre    = '1;
                  r.orig   = '1;
                  r.start  = '1;
                  bad_indexes++;
               end
            end
            default: begin
               seg_count = 0;
            end
         endcase
         mapping_q.push_back(r);
      endfunction

      task check_response(logic [1:0] status, logic [FILE_W-1:0] file,
                          logic [MAP_W-1:0] pre, logic [MAP_W-1:0] orig,
                          logic [LINE_W-1:0] start);
         map_result_type r;
         if (mapping_q.size() == 0) begin
            report_mismatch($sformatf("response transfer with no request pending, status %h",
                                      status));
         end else begin
            r = mapping_q.pop_front();
            checked++;
            if (status !== r.status)
               report_mismatch($sformatf("status %h, expected %h", status, r.status));
            if (file !== r.file)
               report_mismatch($sformatf("file id %h, expected %h", file, r.file));
            if (pre !== r.pre)
               report_mismatch($sformatf("preprocessed line %h, expected %h", pre, r.pre));
            if (orig !== r.orig)
               report_mismatch($sformatf("original line %h, expected %h", orig, r.orig));
            if (start !== r.start)
               report_mismatch($sformatf("start line %h, expected %h", start, r.start));
         end
      endtask
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata  = '0;
   logic [1:0]   req_tuser  = OP_APPEND;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   bit quiet_tail;
   int sent;
   int stall_cycles;
   segment_map_scoreboard sb = new;

   line_segment_map_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_req(op_type op, logic [FILE_W-1:0] fid, logic [LINE_W-1:0] orig,
                           logic [LINE_W-1:0] line, logic [ENTRY_W-1:0] idx);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, idx, line, orig, fid};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, fid, orig, line, idx);
      sent++;
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[7:0], rsp_tdata[39:8], rsp_tdata[71:40],
                           rsp_tdata[102:72]);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("line_segment_map_table_core: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 20))
            @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 1) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [LINE_W-1:0]  cur_line;
      logic [LINE_W-1:0]  first_line;
      logic [LINE_W-1:0]  line;
      logic [LINE_W-1:0]  orig;
      logic [FILE_W-1:0]  fid;
      logic [ENTRY_W-1:0] idx;
      int                 cap;
      int                 appended;
      int                 pick;
      int                 session;
      bit                 long_run;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty table, extreme lines, a segment closed below its start and a wrapping base.
      send_req(OP_READ,   8'd0,  31'd0,    31'd0,    8'd0);
      send_req(OP_FIND,   8'd0,  31'd0,    31'd0,    8'd0);
      send_req(OP_APPEND, 8'd0,  31'd0,    31'd0,    8'd0);
      send_req(OP_APPEND, 8'hFF, LINE_MAX, LINE_MAX, 8'hFF);
      send_req(OP_APPEND, 8'd0,  31'd5,    31'd10,   8'd0);
      send_req(OP_APPEND, 8'hFF, 31'd1,    31'd20,   8'd0);
      send_req(OP_APPEND, 8'd7,  31'd100,  31'd20,   8'd0);
      send_req(OP_APPEND, 8'd7,  31'd200,  31'd20,   8'd0);
      send_req(OP_FIND,   8'd0,  31'd0,    LINE_MAX, 8'd0);
      send_req(OP_FIND,   8'd0,  31'd0,    31'd15,   8'd0);
      send_req(OP_FIND,   8'd0,  31'd0,    31'd20,   8'd0);
      send_req(OP_FIND,   8'd0,  31'd0,    31'd21,   8'd0);
      send_req(OP_FIND,   8'd0,  31'd0,    31'd5,    8'd0);
      send_req(OP_READ,   8'd0,  31'd0,    31'd0,    8'd0);
      send_req(OP_READ,   8'd0,  31'd0,    31'd0,    8'd1);
      send_req(OP_READ,   8'd0,  31'd0,    31'd0,    8'hFF);
      drain_responses();
      send_req(OP_CLEAR,  8'd0,  31'd0,    31'd0,    8'd0);
      send_req(OP_FIND,   8'd0,  31'd0,    31'd3,    8'd0);
      send_req(OP_READ,   8'd0,  31'd0,    31'd0,    8'd0);

      // Each session starts from an empty table; the first one always fills it.
      session = 0;
      while (sent < ITEMS) begin
         long_run   = (session == 0) || ($urandom_range(0, 9) == 0);
         cap        = long_run ? 300 : $urandom_range(1, 40);
         first_line = ($urandom_range(0, 9) == 0) ? LINE_W'($urandom)
                                                  : LINE_W'($urandom_range(0, 2000));
         cur_line   = first_line;
         appended   = 0;
         send_req(OP_CLEAR, FILE_W'($urandom), LINE_W'($urandom), LINE_W'($urandom),
                  ENTRY_W'($urandom));
         while (appended < cap && sent < ITEMS) begin
            quiet_tail = (sent >= ITEMS - QUIET_ITEMS);
            pick       = $urandom_range(0, 99);
            if (pick < 45) begin
               if ($urandom_range(0, 15) == 0) begin
                  line = LINE_W'($urandom_range(first_line, cur_line));
               end else begin
                  cur_line = cur_line + LINE_W'($urandom_range(0, 40));
                  line     = cur_line;
               end
               fid  = ($urandom_range(0, 9) == 0) ? FILE_W'($urandom)
                                                  : FILE_W'($urandom_range(0, 3));
               orig = ($urandom_range(0, 7) == 0) ? LINE_W'($urandom)
                                                  : LINE_W'($urandom_range(1, 5000));
               send_req(OP_APPEND, fid, orig, line, ENTRY_W'($urandom));
               appended++;
            end else if (pick < 75) begin
               line = ($urandom_range(0, 9) == 0) ? LINE_W'($urandom)
                      : LINE_W'($urandom_range(first_line, cur_line + 10));
               send_req(OP_FIND, FILE_W'($urandom), LINE_W'($urandom), line,
                        ENTRY_W'($urandom));
            end else if (pick < 92) begin
               idx = ($urandom_range(0, 7) == 0) ? ENTRY_W'($urandom)
                     : ENTRY_W'($urandom_range(0, (sb.seg_count >= 255) ? 255
                                                                       : sb.seg_count + 1));
               send_req(OP_READ, FILE_W'($urandom), LINE_W'($urandom), LINE_W'($urandom), idx);
            end else begin
               send_req(op_type'($urandom_range(0, long_run ? 2 : 3)), FILE_W'($urandom),
                        LINE_W'($urandom), LINE_W'($urandom), ENTRY_W'($urandom));
            end
         end
         session++;
      end

      drain_responses();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d appends (%0d into a full table), %0d finds (%0d unmatched),",
               sb.op_count[OP_APPEND], sb.full_appends, sb.op_count[OP_FIND],
               sb.missed_finds);
      $display("%0d reads (%0d out of range) and %0d clears; %0d responses checked.",
               sb.op_count[OP_READ], sb.bad_indexes, sb.op_count[OP_CLEAR], sb.checked);
      if (sb.errors == 0)
         $display("line_segment_map_table_core: match");
      else
         $display("line_segment_map_table_core: mismatch");
      $finish;
   end

endmodule
